// ===== hw/rtl/lprt_pkg.sv =====
// shared types and constants for the linear probe route table
`timescale 1ns / 1ps
package lprt_pkg;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int MAX_PROBE_DEF   = 8;
    localparam int ACTIVE_W        = 7;
    localparam int TIMEOUT_W       = 16;
    localparam int KEY_W           = 16;
    localparam int VALUE_W         = 16;
    localparam int TIME_W          = 32;
    localparam int STATUS_W        = 3;
    localparam int REQ_W           = 2;

    localparam logic [REQ_W-1:0] REQ_PUT    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SWEEP  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    localparam logic CFG_ACTIVE  = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [TIME_W-1:0]  now_seconds;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  found_value;
        logic                any_expired;
        logic [ACTIVE_W-1:0] entry_total;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, start home slot reduction
        logic home_step; // one step of the home index reduction
        logic read;      // issue memory read at cursor
        logic eval;      // look at read data, advance cursor
        logic sweep_rd;  // read slot at sweep index
        logic sweep_ev;  // evaluate swept slot
        logic finish;    // form result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic home_done;
        logic probe_done;
        logic sweep_done;
    } t_sts;
endpackage

// ===== hw/rtl/lprt_if.sv =====
// valid/ready channel interface
`timescale 1ns / 1ps
interface lprt_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lprt_cfg_if.sv =====
// configuration write channel interface
`timescale 1ns / 1ps
interface lprt_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/lprt_ctrl.sv =====
// sequencing state machine for the route table
`timescale 1ns / 1ps
module lprt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_is_sweep,
    input  lprt_pkg::t_sts i_sts,
    input  logic          i_out_free,
    output lprt_pkg::t_cmd o_cmd,
    output logic          o_idle
);
    import lprt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_HOME, S_READ, S_EVAL, S_SRD, S_SEV, S_DONE
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_start) r_state <= i_is_sweep ? S_SRD : S_HOME;
                S_HOME: if (i_sts.home_done) r_state <= S_READ;
                S_READ: r_state <= S_EVAL;
                S_EVAL: r_state <= i_sts.probe_done ? S_DONE : S_READ;
                S_SRD:  r_state <= S_SEV;
                S_SEV:  r_state <= i_sts.sweep_done ? S_DONE : S_SRD;
                S_DONE: if (i_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_start;
        o_cmd.home_step = (r_state == S_HOME);
        o_cmd.read      = (r_state == S_READ);
        o_cmd.eval      = (r_state == S_EVAL);
        o_cmd.sweep_rd  = (r_state == S_SRD);
        o_cmd.sweep_ev  = (r_state == S_SEV);
        o_cmd.finish    = (r_state == S_DONE) && i_out_free;
    end

    assign o_idle = (r_state == S_IDLE);
endmodule

// ===== hw/rtl/lprt_dp.sv =====
// table memories, probe cursor and result forming
`timescale 1ns / 1ps
module lprt_dp #(
    parameter int TABLE_DEPTH = lprt_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_PROBE   = lprt_pkg::MAX_PROBE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lprt_pkg::t_req                    i_req,
    input  lprt_pkg::t_cmd                    i_cmd,
    input  logic [lprt_pkg::ACTIVE_W-1:0]     i_active,
    input  logic [lprt_pkg::TIMEOUT_W-1:0]    i_timeout,
    output lprt_pkg::t_sts                    o_sts,
    output lprt_pkg::t_rsp                    o_rsp
);
    import lprt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int NW = IW + 1;
    localparam int PW = $clog2(MAX_PROBE + 1);
    localparam int CW = (NW > ACTIVE_W) ? NW : ACTIVE_W;

    // memories
    logic [KEY_W-1:0]   r_mkey   [TABLE_DEPTH];
    logic [VALUE_W-1:0] r_mval   [TABLE_DEPTH];
    logic [TIME_W-1:0]  r_mstamp [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_used;

    t_req             r_req;
    logic [NW-1:0]    r_n;
    logic [KEY_W+NW-1:0] r_rem;  // shift-subtract remainder work
    logic [4:0]       r_bit;
    logic [IW-1:0]    r_cur;
    logic [PW-1:0]    r_cnt;
    logic             r_free_ok;
    logic [IW-1:0]    r_free;
    logic             r_hit;
    logic [KEY_W-1:0] r_rd_key;
    logic [VALUE_W-1:0] r_rd_val;
    logic [TIME_W-1:0]  r_rd_stamp;
    logic             r_rd_used;
    logic [CW-1:0]    r_count;
    logic             r_exp;
    logic             r_full0;
    t_rsp             r_rsp;

    // effective size
    logic [NW-1:0] w_n;
    always_comb begin
        if (i_active == '0) w_n = NW'(1);
        else if (CW'(i_active) > CW'(TABLE_DEPTH)) w_n = NW'(TABLE_DEPTH);
        else w_n = NW'(i_active);
    end

    // restoring remainder, one key bit per cycle
    logic [NW:0] w_trial;
    logic [NW-1:0] w_remhi;
    assign w_remhi = r_rem[KEY_W+NW-1:KEY_W];
    assign w_trial = {w_remhi, r_rem[KEY_W-1]} - {1'b0, r_n};

    logic [IW-1:0] w_next;
    assign w_next = ({1'b0, r_cur} + 1'b1 == NW'(r_n)) ? '0 : r_cur + 1'b1;

    logic w_match;
    assign w_match = r_rd_used && (r_rd_key == r_req.key);

    logic [TIME_W:0] w_limit;
    assign w_limit = {1'b0, r_rd_stamp} + (TIME_W+1)'(i_timeout);
    logic w_old;
    assign w_old = r_rd_used && ({1'b0, r_req.now_seconds} > w_limit);

    logic [CW-1:0] w_dec;
    assign w_dec = (r_count != '0) ? r_count - 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.read || i_cmd.sweep_rd) begin
            r_rd_key   <= r_mkey[r_cur];
            r_rd_val   <= r_mval[r_cur];
            r_rd_stamp <= r_mstamp[r_cur];
            r_rd_used  <= r_used[r_cur];
        end
        if (i_cmd.load) begin
            r_req     <= i_req;
            r_n       <= w_n;
            r_rem     <= {{NW{1'b0}}, i_req.key};
            r_bit     <= '0;
            r_cur     <= '0;
            r_cnt     <= '0;
            r_free_ok <= 1'b0;
            r_hit     <= 1'b0;
            r_exp     <= 1'b0;
            r_full0   <= ({r_count, 1'b0} >= (CW+1)'(w_n));
        end
        if (i_cmd.home_step) begin
            if (!w_trial[NW]) r_rem <= {w_trial[NW-1:0], r_rem[KEY_W-2:0], 1'b0};
            else              r_rem <= {r_rem[KEY_W+NW-2:0], 1'b0};
            r_bit <= r_bit + 1'b1;
            if (r_bit == 5'(KEY_W - 1)) begin
                r_cur <= !w_trial[NW] ? w_trial[IW-1:0] : r_rem[KEY_W+IW-2:KEY_W-1];
            end
        end
        if (i_cmd.eval) begin
            r_cnt <= r_cnt + 1'b1;
            r_cur <= w_next;
            if (!r_rd_used && !r_free_ok) begin
                r_free_ok <= 1'b1;
                r_free    <= r_cur;
            end
            if (w_match) begin
                r_hit    <= 1'b1;
                if (r_req.req_type == REQ_PUT && !r_full0) begin
                    if (r_free_ok) begin
                        r_used[r_cur]   <= 1'b0;
                        r_used[r_free]  <= 1'b1;
                        r_mkey[r_free]  <= r_req.key;
                        r_mval[r_free]  <= r_req.value;
                        r_mstamp[r_free]<= r_req.now_seconds;
                    end else begin
                        r_mval[r_cur]   <= r_req.value;
                        r_mstamp[r_cur] <= r_req.now_seconds;
                    end
                end else if (r_req.req_type == REQ_REMOVE) begin
                    r_used[r_cur] <= 1'b0;
                    r_count <= w_dec;
                end
            end
        end
        if (i_cmd.sweep_ev) begin
            r_cur <= r_cur + 1'b1;
            if (w_old) begin
                r_used[r_cur] <= 1'b0;
                r_count <= w_dec;
                r_exp <= 1'b1;
            end
        end
        if (i_cmd.finish) begin
            r_rsp.found_value <= (r_req.req_type == REQ_GET && r_hit) ? r_rd_val : '0;
            r_rsp.any_expired <= (r_req.req_type == REQ_SWEEP) && r_exp;
            case (r_req.req_type)
                REQ_PUT: begin
                    if (r_full0) r_rsp.status <= ST_FULL;
                    else if (r_hit) r_rsp.status <= ST_UPDATED;
                    else if (r_free_ok) begin
                        r_rsp.status <= ST_NEW;
                        r_used[r_free]   <= 1'b1;
                        r_mkey[r_free]   <= r_req.key;
                        r_mval[r_free]   <= r_req.value;
                        r_mstamp[r_free] <= r_req.now_seconds;
                    end else r_rsp.status <= ST_FULL;
                end
                REQ_GET: r_rsp.status <= r_hit ? ST_FOUND : ST_MISSING;
                REQ_REMOVE: r_rsp.status <= r_hit ? ST_FOUND : ST_MISSING;
                REQ_SWEEP: r_rsp.status <= r_exp ? ST_FOUND : ST_MISSING;
                default: r_rsp.status <= ST_MISSING;
            endcase
            if (r_req.req_type == REQ_PUT && !r_full0 && !r_hit && r_free_ok)
                r_rsp.entry_total <= ACTIVE_W'(r_count + 1'b1);
            else
                r_rsp.entry_total <= ACTIVE_W'(r_count);
            if (r_req.req_type == REQ_PUT && !r_full0 && !r_hit && r_free_ok)
                r_count <= r_count + 1'b1;
        end
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
        end
    end

    // get keeps read value of the hit slot: stop reading once found
    assign o_sts.home_done  = (r_bit == 5'(KEY_W - 1));
    assign o_sts.probe_done = w_match || (r_cnt == PW'(MAX_PROBE - 1))
                              || (r_req.req_type == REQ_PUT && r_full0);
    assign o_sts.sweep_done = ({1'b0, r_cur} == NW'(r_n - 1'b1));
    assign o_rsp = r_rsp;
endmodule

// ===== hw/rtl/linear_probe_route_table.sv =====
// top level of the linear probe route table
// put/get/remove first reduce the key to its home slot, one key bit a cycle, then
// read and evaluate each probed slot (up to MAX_PROBE) and then form the result;
// sweep reads and evaluates each slot of the active size, then forms the result;
// one request at a time, the next accepted in the cycle after the result is formed;
// a stalled result holds it back
// reset clears the used marks, the entry count and loads the register defaults
`timescale 1ns / 1ps
module linear_probe_route_table #(
    parameter int TABLE_DEPTH = lprt_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_PROBE   = lprt_pkg::MAX_PROBE_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    lprt_if.sink         s_req,
    lprt_if.source       m_rsp,
    lprt_cfg_if.sink     s_cfg
);
    import lprt_pkg::*;

    // configuration registers: write only while idle; the block does not enforce this
    logic [ACTIVE_W-1:0]  r_active;
    logic [TIMEOUT_W-1:0] r_timeout;
    assign s_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= ACTIVE_W'(64);
            r_timeout <= TIMEOUT_W'(60);
        end else if (s_cfg.valid) begin
            case (s_cfg.index)
                CFG_ACTIVE:  r_active  <= s_cfg.wdata[ACTIVE_W-1:0];
                CFG_TIMEOUT: r_timeout <= s_cfg.wdata;
                default: ;
            endcase
        end
    end

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_idle;
    logic r_out_v;

    // output register: a finished result holds until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (w_cmd.finish) r_out_v <= 1'b1;
        else if (m_rsp.ready) r_out_v <= 1'b0;
    end
    assign m_rsp.valid = r_out_v;

    // next request accepted while the previous result may still wait
    assign s_req.ready = w_idle;

    lprt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_req.valid),
        .i_is_sweep (s_req.data.req_type == REQ_SWEEP),
        .i_sts      (w_sts),
        .i_out_free (!r_out_v || m_rsp.ready),
        .o_cmd      (w_cmd),
        .o_idle     (w_idle)
    );

    lprt_dp #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_PROBE(MAX_PROBE)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (s_req.data),
        .i_cmd     (w_cmd),
        .i_active  (r_active),
        .i_timeout (r_timeout),
        .o_sts     (w_sts),
        .o_rsp     (m_rsp.data)
    );
endmodule

// ===== test/tb_linear_probe_route_table.sv =====
// self-checking testbench for the linear probe route table
`timescale 1ns / 1ps
module tb_linear_probe_route_table;
    import lprt_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int PROBE = MAX_PROBE_DEF;
    localparam int RAND_ITEMS = 1150;

    logic i_clk;
    logic i_rst_n;

    lprt_if #(.T(t_req)) req_ch ();
    lprt_if #(.T(t_rsp)) rsp_ch ();
    lprt_cfg_if cfg_ch ();

    linear_probe_route_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_req   (req_ch.sink),
        .m_rsp   (rsp_ch.source),
        .s_cfg   (cfg_ch.sink)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // shadow copy of the table contents
    logic                tbl_used  [DEPTH];
    logic [KEY_W-1:0]    tbl_key   [DEPTH];
    logic [VALUE_W-1:0]  tbl_value [DEPTH];
    logic [TIME_W-1:0]   tbl_stamp [DEPTH];
    int unsigned         tbl_count;
    logic [ACTIVE_W-1:0] sh_active;
    logic [TIMEOUT_W-1:0] sh_timeout;

    t_rsp rsp_pending [$];
    int   mismatch_cnt;
    bit   rsp_stall_en;

    // keys that were put new, used to steer random traffic at hits
    logic [KEY_W-1:0] key_pool [$];

    function automatic int unsigned eff_slots();
        int unsigned n;
        n = sh_active;
        if (n == 0) n = 1;
        if (n > DEPTH) n = DEPTH;
        return n;
    endfunction

    function automatic int lookup_slot(logic [KEY_W-1:0] k);
        int unsigned n;
        int unsigned pos;
        n = eff_slots();
        pos = k % n;
        for (int i = 0; i < PROBE; i++) begin
            if (tbl_used[pos] && tbl_key[pos] == k) return pos;
            pos = (pos + 1) % n;
        end
        return -1;
    endfunction

    function automatic void drop_one();
        if (tbl_count > 0) tbl_count--;
    endfunction

    // apply one request to the shadow table and return the response it causes
    function automatic t_rsp route_step(t_req r);
        t_rsp o;
        int unsigned n;
        int unsigned pos;
        int free_at;
        int target;
        int s;
        o = '0;
        o.status = ST_MISSING;
        n = eff_slots();
        case (r.req_type)
            REQ_PUT: begin
                free_at = -1;
                target = -1;
                if (2 * tbl_count >= n) begin
                    o.status = ST_FULL;
                end else begin
                    pos = r.key % n;
                    for (int i = 0; i < PROBE; i++) begin
                        if (!tbl_used[pos]) begin
                            if (free_at < 0) free_at = pos;
                        end else if (tbl_key[pos] == r.key) begin
                            if (free_at >= 0) begin
                                // relocate toward home into the earlier hole
                                tbl_used[free_at] = 1'b1;
                                tbl_used[pos] = 1'b0;
                            end
                            target = (free_at >= 0) ? free_at : pos;
                            break;
                        end
                        pos = (pos + 1) % n;
                    end
                    if (target < 0 && free_at >= 0) begin
                        target = free_at;
                        tbl_count = (tbl_count + 1) & 7'h7f;
                        tbl_used[target] = 1'b1;
                        o.status = ST_NEW;
                    end else if (target >= 0) begin
                        o.status = ST_UPDATED;
                    end else begin
                        o.status = ST_FULL;
                    end
                    if (target >= 0) begin
                        tbl_key[target] = r.key;
                        tbl_value[target] = r.value;
                        tbl_stamp[target] = r.now_seconds;
                    end
                end
            end
            REQ_GET: begin
                s = lookup_slot(r.key);
                if (s >= 0) begin
                    o.status = ST_FOUND;
                    o.found_value = tbl_value[s];
                end
            end
            REQ_REMOVE: begin
                s = lookup_slot(r.key);
                if (s >= 0) begin
                    tbl_used[s] = 1'b0;
                    drop_one();
                    o.status = ST_FOUND;
                end
            end
            default: begin
                for (int i = 0; i < n; i++) begin
                    if (tbl_used[i] && {1'b0, r.now_seconds} >
                            {1'b0, tbl_stamp[i]} + 33'(sh_timeout)) begin
                        tbl_used[i] = 1'b0;
                        drop_one();
                        o.any_expired = 1'b1;
                    end
                end
                o.status = o.any_expired ? ST_FOUND : ST_MISSING;
            end
        endcase
        o.entry_total = tbl_count[ACTIVE_W-1:0];
        return o;
    endfunction

    // directed rows; exp_ok marks rows whose response is typed in by hand
    typedef struct {
        t_req req;
        bit   exp_ok;
        t_rsp exp;
    } t_row;

    t_row dir_rows [$];

    function automatic t_req mk(logic [REQ_W-1:0] op, logic [KEY_W-1:0] k,
                                logic [VALUE_W-1:0] v, logic [TIME_W-1:0] t);
        t_req r;
        r.req_type = op;
        r.key = k;
        r.value = v;
        r.now_seconds = t;
        return r;
    endfunction

    function automatic t_rsp rs(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] fv,
                                logic ex, logic [ACTIVE_W-1:0] tot);
        t_rsp o;
        o.status = st;
        o.found_value = fv;
        o.any_expired = ex;
        o.entry_total = tot;
        return o;
    endfunction

    function automatic void add_row(t_req r, bit ok, t_rsp e);
        t_row w;
        w.req = r;
        w.exp_ok = ok;
        w.exp = e;
        dir_rows.push_back(w);
    endfunction

    // sender: one transfer, bursts with random gaps in between
    int burst_left;

    task automatic send_req(t_req r);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic issue(t_req r, bit ok, t_rsp e);
        t_rsp p;
        p = route_step(r);
        if (r.req_type == REQ_PUT && p.status == ST_NEW) key_pool.push_back(r.key);
        if (ok && p !== e) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("directed row disagrees with predictor: %p vs %p", e, p);
        end
        rsp_pending.push_back(p);
        send_req(r);
    endtask

    task automatic idle_req();
        req_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        int guard;
        idle_req();
        guard = 0;
        while (rsp_pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        // sweep of a full table plus margin
        repeat (2 * DEPTH + 40) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_ACTIVE) sh_active = d[ACTIVE_W-1:0];
        else sh_timeout = d[TIMEOUT_W-1:0];
    endtask

    function automatic t_req rand_req(logic [TIME_W-1:0] tnow);
        t_req r;
        int sel;
        r.value = 16'($urandom);
        r.now_seconds = tnow;
        sel = $urandom_range(0, 99);
        if (sel < 45) r.req_type = REQ_PUT;
        else if (sel < 75) r.req_type = REQ_GET;
        else if (sel < 95) r.req_type = REQ_REMOVE;
        else r.req_type = REQ_SWEEP;
        // mostly pooled keys or keys that collide on the first home slots
        sel = $urandom_range(0, 9);
        if (sel < 5 && key_pool.size() != 0)
            r.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (sel < 8)
            r.key = 16'($urandom_range(0, 3) * eff_slots() + $urandom_range(0, 7));
        else
            r.key = 16'($urandom);
        if ($urandom_range(0, 40) == 0) r.now_seconds = 32'($urandom);
        return r;
    endfunction

    // response side: random stall pattern, check against oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (rsp_pending.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) $display("unexpected response %p", rsp_ch.data);
                end else begin
                    t_rsp e;
                    e = rsp_pending.pop_front();
                    if (rsp_ch.data.status !== e.status ||
                        rsp_ch.data.found_value !== e.found_value ||
                        rsp_ch.data.any_expired !== e.any_expired ||
                        rsp_ch.data.entry_total !== e.entry_total) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("response mismatch: expected %p, got %p", e, rsp_ch.data);
                    end
                end
            end
            rsp_ch.ready <= rsp_stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // stall phases change independently of the sender
    initial begin
        rsp_stall_en = 1'b0;
        forever begin
            repeat ($urandom_range(50, 400)) @(posedge i_clk);
            rsp_stall_en <= ~rsp_stall_en;
        end
    end

    initial begin
        #50_000_000;
        $display("tb_linear_probe_route_table NOT OK");
        $finish;
    end

    logic [TIME_W-1:0] clock_s;

    initial begin
        mismatch_cnt = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_ACTIVE;
        cfg_ch.wdata = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_used[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_value[i] = '0;
            tbl_stamp[i] = '0;
        end
        tbl_count = 0;
        sh_active = 7'd64;
        sh_timeout = 16'd60;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, every request, sweep edge
        add_row(mk(REQ_GET, 16'h0000, 16'h0, 32'd0), 1, rs(ST_MISSING, 0, 0, 0));
        add_row(mk(REQ_REMOVE, 16'hFFFF, 16'h0, 32'd0), 1, rs(ST_MISSING, 0, 0, 0));
        add_row(mk(REQ_SWEEP, 16'h0, 16'h0, 32'hFFFF_FFFF), 1, rs(ST_MISSING, 0, 0, 0));
        add_row(mk(REQ_PUT, 16'h0000, 16'hFFFF, 32'd100), 1, rs(ST_NEW, 0, 0, 1));
        add_row(mk(REQ_PUT, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF), 1, rs(ST_NEW, 0, 0, 2));
        add_row(mk(REQ_GET, 16'h0000, 16'h0, 32'd0), 1, rs(ST_FOUND, 16'hFFFF, 0, 2));
        add_row(mk(REQ_PUT, 16'h0000, 16'h1234, 32'd160), 1, rs(ST_UPDATED, 0, 0, 2));
        add_row(mk(REQ_PUT, 16'h0040, 16'h5555, 32'd160), 1, rs(ST_NEW, 0, 0, 3));
        add_row(mk(REQ_PUT, 16'h0080, 16'hAAAA, 32'd160), 1, rs(ST_NEW, 0, 0, 4));
        add_row(mk(REQ_REMOVE, 16'h0000, 16'h0, 32'd0), 1, rs(ST_FOUND, 0, 0, 3));
        // key now moves back into the freed home slot
        add_row(mk(REQ_PUT, 16'h0080, 16'h0101, 32'd170), 1, rs(ST_UPDATED, 0, 0, 3));
        add_row(mk(REQ_GET, 16'h0080, 16'h0, 32'd0), 1, rs(ST_FOUND, 16'h0101, 0, 3));
        add_row(mk(REQ_SWEEP, 16'h0, 16'h0, 32'd220), 1, rs(ST_MISSING, 0, 0, 3));
        add_row(mk(REQ_SWEEP, 16'h0, 16'h0, 32'd221), 1, rs(ST_FOUND, 0, 1, 2));
        add_row(mk(REQ_GET, 16'hFFFF, 16'h0, 32'd0), 0, '0);
        add_row(mk(REQ_SWEEP, 16'h0, 16'h0, 32'd300), 0, '0);
        foreach (dir_rows[i]) issue(dir_rows[i].req, dir_rows[i].exp_ok, dir_rows[i].exp);
        drain();

        // tiny table: size zero behaves as one, full status
        write_cfg(CFG_ACTIVE, 16'd0);
        write_cfg(CFG_TIMEOUT, 16'd0);
        issue(mk(REQ_PUT, 16'h0007, 16'h0077, 32'd5), 0, '0);
        issue(mk(REQ_PUT, 16'h0008, 16'h0088, 32'd5), 0, '0);
        issue(mk(REQ_SWEEP, 16'h0, 16'h0, 32'd5), 0, '0);
        issue(mk(REQ_SWEEP, 16'h0, 16'h0, 32'd6), 0, '0);
        issue(mk(REQ_REMOVE, 16'h0007, 16'h0, 32'd6), 0, '0);
        drain();
        write_cfg(CFG_ACTIVE, 16'hFFFF);
        write_cfg(CFG_TIMEOUT, 16'hFFFF);
        issue(mk(REQ_SWEEP, 16'h0, 16'h0, 32'hFFFF_FFFF), 0, '0);
        drain();

        // random phases over several settings
        clock_s = 32'd1000;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_cfg(CFG_ACTIVE, 16'd64); write_cfg(CFG_TIMEOUT, 16'd60); end
                1: begin write_cfg(CFG_ACTIVE, 16'd5); write_cfg(CFG_TIMEOUT, 16'd0); end
                2: begin write_cfg(CFG_ACTIVE, 16'd127); write_cfg(CFG_TIMEOUT, 16'hFFFF); end
                3: begin write_cfg(CFG_ACTIVE, 16'd1); write_cfg(CFG_TIMEOUT, 16'd3); end
                4: begin
                    write_cfg(CFG_ACTIVE, 16'($urandom_range(2, 64)));
                    write_cfg(CFG_TIMEOUT, 16'($urandom_range(0, 200)));
                end
                default: begin write_cfg(CFG_ACTIVE, 16'd32); write_cfg(CFG_TIMEOUT, 16'd20); end
            endcase
            for (int i = 0; i < RAND_ITEMS / 6; i++) begin
                clock_s = clock_s + $urandom_range(0, 4);
                issue(rand_req(clock_s), 0, '0);
            end
            drain();
        end

        if (mismatch_cnt == 0 && rsp_pending.size() == 0) begin
            $display("tb_linear_probe_route_table OK");
        end else begin
            $display("tb_linear_probe_route_table NOT OK");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/lprt_pkg.sv
hw/rtl/lprt_if.sv
hw/rtl/lprt_cfg_if.sv
hw/rtl/lprt_ctrl.sv
hw/rtl/lprt_dp.sv
hw/rtl/linear_probe_route_table.sv
test/tb_linear_probe_route_table.sv
